### src/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared opcodes, direction flags and the default coordinate width for the line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

   // default coordinate width
   localparam int unsigned COORD_BITS_DEF = 12;

   // item opcodes
   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   // step directions and major axis of the active line
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic y_major;
   } line_dir_type;

endpackage

### src/bls_setup.sv
// ----------------------------------------------------------------------------
// Line setup
// Forms absolute deltas, step directions, major axis and the initial error
// term from the start and end points of a new line.
// ----------------------------------------------------------------------------
module bls_setup #(
   parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   output logic [COORD_BITS-1:0] major_delta,
   output logic [COORD_BITS-1:0] minor_delta,
   output logic [COORD_BITS+2:0] error_init,
   output bls_pkg::line_dir_type dir
);
   import bls_pkg::*;

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;

   // pick direction and magnitude on each axis
   always_comb begin
      dir.x_neg = end_x < start_x;
      dir.y_neg = end_y < start_y;
      dx = dir.x_neg ? start_x - end_x : end_x - start_x;
      dy = dir.y_neg ? start_y - end_y : end_y - start_y;
      // equal deltas keep x as the major axis
      dir.y_major = dy > dx;
   end

   assign major_delta = dir.y_major ? dy : dx;
   assign minor_delta = dir.y_major ? dx : dy;

   // error term 2*minor - major
   assign error_init = {2'b00, minor_delta, 1'b0} - {3'b000, major_delta};

endmodule

### src/bls_step.sv
// ----------------------------------------------------------------------------
// Pixel step
// Advances the current pixel one place along the major axis, moves the minor
// axis when the error term is not negative, and updates the error term.
// ----------------------------------------------------------------------------
module bls_step #(
   parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0] cur_x,
   input  logic [COORD_BITS-1:0] cur_y,
   input  logic [COORD_BITS+2:0] error_term,
   input  logic [COORD_BITS-1:0] major_delta,
   input  logic [COORD_BITS-1:0] minor_delta,
   input  bls_pkg::line_dir_type dir,
   output logic [COORD_BITS-1:0] next_x,
   output logic [COORD_BITS-1:0] next_y,
   output logic [COORD_BITS+2:0] next_error
);
   import bls_pkg::*;

   localparam int unsigned ERR_BITS = COORD_BITS + 3;

   logic                  move_minor;
   logic                  move_x;
   logic                  move_y;
   logic [COORD_BITS-1:0] x_delta;
   logic [COORD_BITS-1:0] y_delta;
   logic [COORD_BITS:0]   diff;
   logic [ERR_BITS-1:0]   err_inc;

   // minor axis moves when the error term is not negative
   assign move_minor = ~error_term[ERR_BITS-1];
   assign move_x     = ~dir.y_major | move_minor;
   assign move_y     =  dir.y_major | move_minor;

   // step by +1 or -1, wrapping at the coordinate width
   assign x_delta = dir.x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   assign y_delta = dir.y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   assign next_x  = move_x ? cur_x + x_delta : cur_x;
   assign next_y  = move_y ? cur_y + y_delta : cur_y;

   // error gains 2*(minor - major) on a minor move, else 2*minor
   assign diff    = {1'b0, minor_delta} - {1'b0, major_delta};
   assign err_inc = move_minor ? {diff[COORD_BITS], diff, 1'b0}
                               : {2'b00, minor_delta, 1'b0};
   assign next_error = error_term + err_inc;

endmodule

### src/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Integer line rasterizer for all eight octants: a load item sets up a line
// and returns its start pixel, each step item returns the next pixel.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the input register, then the setup or
// step logic into the result register. Throughput: one item per cycle
// unless the result stalls; the line state loops through one step unit.
// A stalled result holds the input register and stalls req in the same cycle.
// Reset: synchronous; drops any item in flight and leaves no line active.
module bresenham_line_stepper #(
   parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bls_pkg::opcode_type    req_opcode,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y,
   output logic                   rsp_last_pixel,
   output logic                   rsp_no_pixel
);
   import bls_pkg::*;

   localparam int unsigned ERR_BITS = COORD_BITS + 3;

   // input register
   logic                  in_valid_ff;
   opcode_type            in_op_ff;
   logic [COORD_BITS-1:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;

   // line state
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [ERR_BITS-1:0]   err_ff, err_in;
   logic [COORD_BITS-1:0] major_ff, major_in;
   logic [COORD_BITS-1:0] minor_ff, minor_in;
   line_dir_type          dir_ff, dir_in;
   logic [COORD_BITS-1:0] remain_ff, remain_in;
   logic                  active_ff, active_in;

   // result register
   logic                  rsp_valid_ff;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_none_ff, rsp_none_in;

   // setup and step outputs
   logic [COORD_BITS-1:0] set_major, set_minor;
   logic [ERR_BITS-1:0]   set_err;
   line_dir_type          set_dir;
   logic [COORD_BITS-1:0] stp_x, stp_y;
   logic [ERR_BITS-1:0]   stp_err;
   logic [COORD_BITS-1:0] remain_dec;

   logic out_ready;
   logic in_ready;
   logic fire;

   // pipeline flow: each stage moves when the one after it can take the item
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;
   assign in_ready  = ~in_valid_ff | out_ready;
   assign fire      = in_valid_ff & out_ready;
   assign req_stall = ~in_ready;

   bls_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .start_x     (in_sx_ff),
      .start_y     (in_sy_ff),
      .end_x       (in_ex_ff),
      .end_y       (in_ey_ff),
      .major_delta (set_major),
      .minor_delta (set_minor),
      .error_init  (set_err),
      .dir         (set_dir)
   );

   bls_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cur_x       (cur_x_ff),
      .cur_y       (cur_y_ff),
      .error_term  (err_ff),
      .major_delta (major_ff),
      .minor_delta (minor_ff),
      .dir         (dir_ff),
      .next_x      (stp_x),
      .next_y      (stp_y),
      .next_error  (stp_err)
   );

   assign remain_dec = remain_ff - COORD_BITS'(1);

   // decode the item and form the next line state and result
   always_comb begin
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      err_in      = err_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      dir_in      = dir_ff;
      remain_in   = remain_ff;
      active_in   = active_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_last_in = rsp_last_ff;
      rsp_none_in = rsp_none_ff;
      if (fire) begin
         unique case (in_op_ff)
            OP_LOAD: begin
               cur_x_in    = in_sx_ff;
               cur_y_in    = in_sy_ff;
               err_in      = set_err;
               major_in    = set_major;
               minor_in    = set_minor;
               dir_in      = set_dir;
               remain_in   = set_major;
               active_in   = set_major != '0;
               rsp_x_in    = in_sx_ff;
               rsp_y_in    = in_sy_ff;
               rsp_last_in = set_major == '0;
               rsp_none_in = 1'b0;
            end
            OP_STEP: begin
               if (active_ff) begin
                  cur_x_in    = stp_x;
                  cur_y_in    = stp_y;
                  err_in      = stp_err;
                  remain_in   = remain_dec;
                  active_in   = remain_dec != '0;
                  rsp_x_in    = stp_x;
                  rsp_y_in    = stp_y;
                  rsp_last_in = remain_dec == '0;
                  rsp_none_in = 1'b0;
               end else begin
                  rsp_x_in    = '0;
                  rsp_y_in    = '0;
                  rsp_last_in = 1'b0;
                  rsp_none_in = 1'b1;
               end
            end
            default: begin
               rsp_none_in = 1'b1;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= in_valid_ff;
         end
         active_ff <= active_in;
      end
   end

   // payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_op_ff <= req_opcode;
         in_sx_ff <= req_start_x;
         in_sy_ff <= req_start_y;
         in_ex_ff <= req_end_x;
         in_ey_ff <= req_end_y;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      err_ff      <= err_in;
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      dir_ff      <= dir_in;
      remain_ff   <= remain_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_last_pixel = rsp_last_ff;
   assign rsp_no_pixel   = rsp_none_ff;

   // an active line always has steps left
   a_active_remain: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> remain_ff != '0)
      else $error("active line with no steps left");

   // a no-pixel result carries no coordinates and no last mark
   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |->
         (!rsp_last_ff && rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("no-pixel result with coordinates or last mark");

   // the final step ends the line and marks its result last
   a_final_step: assert property (@(posedge clock) disable iff (reset)
      (fire && in_op_ff == OP_STEP && active_ff && remain_ff == COORD_BITS'(1))
         |=> (!active_ff && rsp_last_ff && rsp_valid_ff))
      else $error("final step did not end the line");

   // stall only while the input register holds an item that cannot move
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked item");

endmodule
